/* rtl/core/hcmp_pkg.sv */
package hcmp_pkg;

	// Geometry of the hybrid set
	localparam int SETS      = 1024;
	localparam int NVM_WAYS  = 12;
	localparam int SRAM_WAYS = 4;
	localparam int LIMIT_MAX = 20;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int NW_W  = (NVM_WAYS > 1) ? $clog2(NVM_WAYS) : 1;
	localparam int SW_W  = (SRAM_WAYS > 1) ? $clog2(SRAM_WAYS) : 1;

	// Counters and thresholds
	localparam int                CNT_W       = 5;
	localparam logic [CNT_W-1:0]  CNT_TOP     = 5'd31;
	localparam int                LIMIT_W     = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 5'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_TOP   = LIMIT_W'(LIMIT_MAX);

	// Error scaling for the frame-end adaptation (errors * scale > accesses)
	localparam int PROD_W         = 24;
	localparam int NVM_ERR_SCALE  = 100;
	localparam int SRAM_ERR_SCALE = 200;

	// Request modes
	localparam logic [1:0] MODE_ACCESS = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_FRAME  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [9:0]  set_index;
		logic [3:0]  way;
		logic        in_nvm;
		logic        is_write;
		logic [3:0]  victim_way;
		logic [15:0] nvm_errors;
		logic [15:0] sram_errors;
		logic [15:0] frame_accesses;
	} req_t;

	typedef struct packed {
		logic        alloc_to_nvm;
		logic        migrate;
		logic        migrate_from_nvm;
		logic [1:0]  sram_way;
		logic [3:0]  nvm_way;
		logic [4:0]  nvm_threshold;
		logic [4:0]  sram_threshold;
	} rsp_t;

	// One memory row holds all counters of one set in one table
	typedef logic [NVM_WAYS-1:0][CNT_W-1:0]  nvm_row_t;
	typedef logic [SRAM_WAYS-1:0][CNT_W-1:0] sram_row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

/* rtl/core/hcmp_ram.sv */
module hcmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/hybrid_cache_migration_predictor_unit.sv */
// The set's counter rows are read on acceptance; done and the result are
// registered from the EXEC state. No second request is taken meanwhile:
// busy is high in the cycle after acceptance while the set's counter rows are
// read, updated and written back. Results cannot be stalled: done is high for
// exactly one cycle per request. Reset: thresholds return to 3 and a clearing
// pass zeroes one set row per cycle, with busy high before the first request.
module hybrid_cache_migration_predictor_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  hcmp_pkg::req_t  req,
	output logic            done,
	output hcmp_pkg::rsp_t  rsp
);

	hcmp_pkg::state_t state_q, state_d;

	logic [hcmp_pkg::SET_W-1:0]   clr_q;
	hcmp_pkg::req_t               req_s1;
	logic [hcmp_pkg::LIMIT_W-1:0] nvm_lim_q, sram_lim_q;
	logic [hcmp_pkg::LIMIT_W-1:0] nvm_lim_d, sram_lim_d;
	hcmp_pkg::rsp_t               rsp_q, rsp_d;
	logic                         done_q;

	logic accept, clearing, exec, ram_we;
	logic [hcmp_pkg::SET_W-1:0] waddr, raddr;

	hcmp_pkg::nvm_row_t  nrow, nrow_new, nrow_wr;
	hcmp_pkg::sram_row_t srow, srow_new, srow_wr;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hcmp_pkg::ST_CLEAR: begin
				if (clr_q == hcmp_pkg::SET_W'(hcmp_pkg::SETS - 1)) state_d = hcmp_pkg::ST_IDLE;
			end
			hcmp_pkg::ST_IDLE: begin
				if (start) state_d = hcmp_pkg::ST_EXEC;
			end
			hcmp_pkg::ST_EXEC: state_d = hcmp_pkg::ST_IDLE;
			default: state_d = hcmp_pkg::ST_CLEAR;
		endcase
	end

	// State outputs
	always_comb begin
		busy     = 1'b1;
		clearing = 1'b0;
		exec     = 1'b0;
		case (state_q)
			hcmp_pkg::ST_CLEAR: clearing = 1'b1;
			hcmp_pkg::ST_IDLE:  busy = 1'b0;
			hcmp_pkg::ST_EXEC:  exec = 1'b1;
			default:            clearing = 1'b0;
		endcase
	end

	assign accept = start & ~busy;
	assign raddr  = hcmp_pkg::SET_W'(req.set_index);

	// State register and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcmp_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
		end
	end

	// Hold the request for the update cycle
	always_ff @(posedge clk) begin
		if (accept) req_s1 <= req;
	end

	// Counter memories, one row per set
	hcmp_ram #(
		.WIDTH(hcmp_pkg::NVM_WAYS * hcmp_pkg::CNT_W),
		.DEPTH(hcmp_pkg::SETS)
	) u_nvm_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (nrow_wr),
		.re    (accept),
		.raddr (raddr),
		.rdata (nrow)
	);

	hcmp_ram #(
		.WIDTH(hcmp_pkg::SRAM_WAYS * hcmp_pkg::CNT_W),
		.DEPTH(hcmp_pkg::SETS)
	) u_sram_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (srow_wr),
		.re    (accept),
		.raddr (raddr),
		.rdata (srow)
	);

	// Counter update
	logic                        set_ok, line_ok, nvm, raise, hit, vic_ok;
	logic                        is_access, is_insert, is_frame;
	logic [hcmp_pkg::NW_W-1:0]   nw_own, nw_vic;
	logic [hcmp_pkg::SW_W-1:0]   sw_own, sw_vic;
	logic [hcmp_pkg::CNT_W-1:0]  cnt, cnt_up, cnt_dn, cnt_new;
	logic [hcmp_pkg::LIMIT_W-1:0] lim;

	always_comb begin
		nvm       = req_s1.in_nvm;
		is_access = (req_s1.mode == hcmp_pkg::MODE_ACCESS);
		is_insert = (req_s1.mode == hcmp_pkg::MODE_INSERT);
		is_frame  = (req_s1.mode == hcmp_pkg::MODE_FRAME);
		set_ok    = 32'(req_s1.set_index) < hcmp_pkg::SETS;
		nw_own    = hcmp_pkg::NW_W'(req_s1.way);
		sw_own    = hcmp_pkg::SW_W'(req_s1.way);
		nw_vic    = hcmp_pkg::NW_W'(req_s1.victim_way);
		sw_vic    = hcmp_pkg::SW_W'(req_s1.victim_way);
		if (nvm) begin
			line_ok = set_ok && (32'(req_s1.way) < hcmp_pkg::NVM_WAYS);
			vic_ok  = 32'(req_s1.victim_way) < hcmp_pkg::SRAM_WAYS;
			cnt     = line_ok ? nrow[nw_own] : '0;
			lim     = nvm_lim_q;
			raise   = req_s1.is_write;
		end else begin
			line_ok = set_ok && (32'(req_s1.way) < hcmp_pkg::SRAM_WAYS);
			vic_ok  = 32'(req_s1.victim_way) < hcmp_pkg::NVM_WAYS;
			cnt     = line_ok ? srow[sw_own] : '0;
			lim     = sram_lim_q;
			raise   = ~req_s1.is_write;
		end
		cnt_up = (cnt == hcmp_pkg::CNT_TOP) ? hcmp_pkg::CNT_TOP : cnt + 1'b1;
		cnt_dn = (cnt == '0) ? '0 : cnt - 1'b1;
		hit    = is_access && line_ok && raise && (cnt_up == lim);

		if (is_access) cnt_new = raise ? (hit ? '0 : cnt_up) : cnt_dn;
		else           cnt_new = '0;

		nrow_new = nrow;
		srow_new = srow;
		if (line_ok && (is_access || is_insert)) begin
			if (nvm) nrow_new[nw_own] = cnt_new;
			else     srow_new[sw_own] = cnt_new;
		end
		// Clear the victim line in the other table on a migration
		if (hit && vic_ok) begin
			if (nvm) srow_new[sw_vic] = '0;
			else     nrow_new[nw_vic] = '0;
		end
	end

	// Write back the updated rows, or zeros during the clearing sweep
	assign ram_we  = clearing | (exec & set_ok);
	assign waddr   = clearing ? clr_q : hcmp_pkg::SET_W'(req_s1.set_index);
	assign nrow_wr = clearing ? '0 : nrow_new;
	assign srow_wr = clearing ? '0 : srow_new;

	// Frame-end threshold adaptation
	logic [hcmp_pkg::PROD_W-1:0] nvm_prod, sram_prod, acc_ext;
	logic                        adapt;

	always_comb begin
		nvm_prod  = hcmp_pkg::PROD_W'(req_s1.nvm_errors)
		          * hcmp_pkg::PROD_W'(hcmp_pkg::NVM_ERR_SCALE);
		sram_prod = hcmp_pkg::PROD_W'(req_s1.sram_errors)
		          * hcmp_pkg::PROD_W'(hcmp_pkg::SRAM_ERR_SCALE);
		acc_ext   = hcmp_pkg::PROD_W'(req_s1.frame_accesses);
		adapt     = exec && is_frame && (req_s1.frame_accesses != '0);
		nvm_lim_d  = nvm_lim_q;
		sram_lim_d = sram_lim_q;
		if (adapt) begin
			if (nvm_prod > acc_ext)
				nvm_lim_d = (nvm_lim_q > hcmp_pkg::LIMIT_MIN) ? nvm_lim_q - 1'b1
				                                              : hcmp_pkg::LIMIT_MIN;
			else
				nvm_lim_d = (nvm_lim_q >= hcmp_pkg::LIMIT_TOP) ? hcmp_pkg::LIMIT_TOP
				                                               : nvm_lim_q + 1'b1;
			if (sram_prod > acc_ext)
				sram_lim_d = (sram_lim_q > hcmp_pkg::LIMIT_MIN) ? sram_lim_q - 1'b1
				                                                : hcmp_pkg::LIMIT_MIN;
			else
				sram_lim_d = (sram_lim_q >= hcmp_pkg::LIMIT_TOP) ? hcmp_pkg::LIMIT_TOP
				                                                 : sram_lim_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvm_lim_q  <= hcmp_pkg::LIMIT_RESET;
			sram_lim_q <= hcmp_pkg::LIMIT_RESET;
		end else begin
			nvm_lim_q  <= nvm_lim_d;
			sram_lim_q <= sram_lim_d;
		end
	end

	// Assemble the result
	always_comb begin
		rsp_d                  = '0;
		rsp_d.alloc_to_nvm     = ~req_s1.is_write;
		rsp_d.migrate          = hit;
		rsp_d.migrate_from_nvm = hit & nvm;
		if (hit) begin
			rsp_d.sram_way = nvm ? req_s1.victim_way[1:0] : req_s1.way[1:0];
			rsp_d.nvm_way  = nvm ? req_s1.way : req_s1.victim_way;
		end
		rsp_d.nvm_threshold  = nvm_lim_d;
		rsp_d.sram_threshold = sram_lim_d;
	end

	// Register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= exec;
	end

	always_ff @(posedge clk) begin
		if (exec) rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
